// ===== hw/rtl/acrs_pkg.sv =====
// shared types and constants for the actuator command refresh scheduler
package acrs_pkg;

    localparam int NUM_TGT     = 7;
    localparam int NUM_MSG     = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // target slots
    localparam int IDX_FL     = 0;
    localparam int IDX_FR     = 1;
    localparam int IDX_BL     = 2;
    localparam int IDX_BR     = 3;
    localparam int IDX_INTAKE = 4;
    localparam int IDX_DUMP   = 5;
    localparam int IDX_DEPLOY = 6;

    typedef enum logic [1:0] {
        OP_GAMEPAD   = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_DISABLE   = 2'd2,
        OP_SERVICE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_HEARTBEAT = 3'd0,
        KIND_DRIVE     = 3'd1,
        KIND_INTAKE    = 3'd2,
        KIND_DUMP      = 3'd3,
        KIND_DEPLOY    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_HB_PERIOD   = 3'd0,
        CFG_REF_PERIOD  = 3'd1,
        CFG_CRAWL       = 3'd2,
        CFG_INTAKE      = 3'd3,
        CFG_DUMP        = 3'd4,
        CFG_DEPLOY_LOW  = 3'd5,
        CFG_DEPLOY_RAIS = 3'd6,
        CFG_DEADZONE    = 3'd7
    } t_cfg_idx;

    localparam logic [15:0]       RST_HB_PERIOD   = 16'd1000;
    localparam logic [15:0]       RST_REF_PERIOD  = 16'd1000;
    localparam logic [6:0]        RST_CRAWL       = 7'd40;
    localparam logic [6:0]        RST_INTAKE      = 7'd100;
    localparam logic [6:0]        RST_DUMP        = 7'd100;
    localparam logic signed [7:0] RST_DEPLOY_LOW  = -8'sd15;
    localparam logic signed [7:0] RST_DEPLOY_RAIS = 8'sd65;
    localparam logic [7:0]        RST_DEADZONE    = 8'd10;

    typedef struct packed {
        logic [15:0]       hb_period;
        logic [15:0]       ref_period;
        logic [6:0]        crawl;
        logic [6:0]        intake;
        logic [6:0]        dump;
        logic signed [7:0] deploy_low;
        logic signed [7:0] deploy_raise;
        logic [7:0]        deadzone;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        pad;
        logic [31:0]       time_or_enable;
        logic [7:0]        right_trigger;
        logic [7:0]        left_trigger;
        logic              right_bumper;
        logic              left_bumper;
        logic              button_b;
        logic              button_a;
        logic              dpad_down;
        logic              dpad_up;
        logic signed [7:0] right_stick_y;
        logic signed [7:0] left_stick_y;
    } t_in_data;

    typedef struct packed {
        logic [6:0]        pad;
        logic              robot_enabled;
        logic signed [7:0] value_back_right;
        logic signed [7:0] value_back_left;
        logic signed [7:0] value_front_right;
        logic signed [7:0] value_front_left;
    } t_out_data;

    // one scheduled service run: due mask by message kind, target snapshot, enable
    typedef struct packed {
        logic [NUM_MSG-1:0]            due;
        logic [NUM_TGT-1:0][7:0]       vals;
        logic                          enabled;
    } t_entry;

endpackage

// ===== hw/rtl/acrs_front.sv =====
// front end: accepts beats, keeps targets and send timers, schedules service runs
module acrs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acrs_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  acrs_pkg::t_op        i_op,
    input  acrs_pkg::t_in_data   i_data,
    output logic                 o_push,
    output acrs_pkg::t_entry     o_entry
);
    import acrs_pkg::*;

    logic [NUM_TGT-1:0][7:0] r_tgt;
    logic [NUM_TGT-1:0][7:0] n_tgt;
    logic [NUM_TGT-1:0][7:0] r_sent;
    logic [NUM_MSG-1:0][31:0] r_last;
    logic                    r_en;

    logic [7:0]         crawl8;
    logic [7:0]         left_v;
    logic [7:0]         right_v;
    logic [7:0]         deploy_v;
    logic [8:0]         rt_x3;
    logic [NUM_MSG-1:0] due;
    logic               drive_chg;
    logic [31:0]        now;
    logic               is_service;

    assign now        = i_data.time_or_enable;
    assign is_service = i_accept && (i_op == OP_SERVICE);
    assign crawl8     = {1'b0, i_cfg.crawl};
    assign rt_x3      = {1'b0, i_data.right_trigger[7:1], 1'b0}
                      + {2'b00, i_data.right_trigger[7:1]};

    always_comb begin
        if (i_data.dpad_up) begin
            left_v  = crawl8;
            right_v = crawl8;
        end else if (i_data.dpad_down) begin
            left_v  = 8'(8'd0 - crawl8);
            right_v = 8'(8'd0 - crawl8);
        end else begin
            left_v  = i_data.left_stick_y;
            right_v = i_data.right_stick_y;
        end

        if (i_data.left_bumper) begin
            deploy_v = i_cfg.deploy_low;
        end else if (i_data.right_bumper) begin
            deploy_v = i_cfg.deploy_raise;
        end else if (i_data.left_trigger > i_cfg.deadzone) begin
            deploy_v = 8'(8'd0 - {1'b0, i_data.left_trigger[7:1]});
        end else if (i_data.right_trigger > i_cfg.deadzone) begin
            deploy_v = (rt_x3 > 9'd127) ? 8'd127 : rt_x3[7:0];
        end else begin
            deploy_v = 8'd0;
        end

        n_tgt             = r_tgt;
        n_tgt[IDX_FL]     = left_v;
        n_tgt[IDX_BL]     = left_v;
        n_tgt[IDX_FR]     = right_v;
        n_tgt[IDX_BR]     = right_v;
        n_tgt[IDX_INTAKE] = i_data.button_a ? {1'b0, i_cfg.intake} : 8'd0;
        n_tgt[IDX_DUMP]   = i_data.button_b ? {1'b0, i_cfg.dump} : 8'd0;
        n_tgt[IDX_DEPLOY] = deploy_v;
    end

    always_comb begin
        drive_chg = 1'b0;
        for (int i = IDX_FL; i <= IDX_BR; i++) begin
            if (r_tgt[i] != r_sent[i]) drive_chg = 1'b1;
        end
        due[KIND_HEARTBEAT] = (32'(now - r_last[KIND_HEARTBEAT]))
                            > {16'd0, i_cfg.hb_period};
        due[KIND_DRIVE]     = drive_chg || ((32'(now - r_last[KIND_DRIVE]))
                            > {16'd0, i_cfg.ref_period});
        for (int i = 0; i < 3; i++) begin
            due[KIND_INTAKE + i] = (r_tgt[IDX_INTAKE + i] != r_sent[IDX_INTAKE + i])
                                || ((32'(now - r_last[KIND_INTAKE + i]))
                                    > {16'd0, i_cfg.ref_period});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt  <= '0;
            r_sent <= '0;
            r_last <= '0;
            r_en   <= 1'b0;
        end else if (i_accept) begin
            unique case (i_op)
                OP_GAMEPAD:   r_tgt <= n_tgt;
                OP_HEARTBEAT: r_en  <= i_data.time_or_enable[0];
                OP_DISABLE:   r_en  <= 1'b0;
                OP_SERVICE: begin
                    r_sent <= r_tgt;
                    for (int i = 0; i < NUM_MSG; i++) begin
                        if (due[i]) r_last[i] <= now;
                    end
                end
            endcase
        end
    end

    assign o_push        = is_service && (due != '0);
    assign o_entry.due     = due;
    assign o_entry.vals    = r_tgt;
    assign o_entry.enabled = r_en;

endmodule

// ===== hw/rtl/acrs_queue.sv =====
// short queue of scheduled service runs between front and back
module acrs_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  acrs_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output acrs_pkg::t_entry o_entry
);
    import acrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= f_inc(r_wr);
            if (i_pop)  r_rd <= f_inc(r_rd);
            if (i_push && !i_pop)      r_cnt <= CW'(r_cnt + 1'b1);
            else if (i_pop && !i_push) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue pop while empty");

endmodule

// ===== hw/rtl/acrs_back.sv =====
// back end: expands a scheduled run into message beats, one per cycle while the master side is ready
module acrs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  acrs_pkg::t_entry      i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output acrs_pkg::t_kind       o_kind,
    output acrs_pkg::t_out_data   o_data,
    output logic                  o_last
);
    import acrs_pkg::*;

    t_entry             r_ent;
    logic [NUM_MSG-1:0] r_mask;
    logic               r_act;
    logic               r_out_valid;
    t_kind              r_out_kind;
    t_out_data          r_out_data;
    logic               r_out_last;

    logic               advance;
    logic [NUM_MSG-1:0] rest;
    logic               load;
    t_kind              sel;
    t_out_data          beat;

    assign advance = !r_out_valid || i_ready;
    assign rest    = r_mask & (r_mask - 1'b1);
    assign load    = i_q_valid && (!r_act || (advance && (rest == '0)));
    assign o_q_pop = load;

    always_comb begin
        sel = KIND_DEPLOY;
        for (int i = NUM_MSG - 1; i >= 0; i--) begin
            if (r_mask[i]) sel = t_kind'(i);
        end
    end

    always_comb begin
        beat               = '0;
        beat.robot_enabled = r_ent.enabled;
        unique case (sel)
            KIND_HEARTBEAT: ;
            KIND_DRIVE: begin
                beat.value_front_left  = r_ent.vals[IDX_FL];
                beat.value_front_right = r_ent.vals[IDX_FR];
                beat.value_back_left   = r_ent.vals[IDX_BL];
                beat.value_back_right  = r_ent.vals[IDX_BR];
            end
            KIND_INTAKE: beat.value_front_left = r_ent.vals[IDX_INTAKE];
            KIND_DUMP:   beat.value_front_left = r_ent.vals[IDX_DUMP];
            KIND_DEPLOY: beat.value_front_left = r_ent.vals[IDX_DEPLOY];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_act;
                if (r_act) r_mask <= rest;
            end
            if (load) begin
                r_act  <= 1'b1;
                r_mask <= i_q_entry.due;
            end else if (r_act && advance && (rest == '0)) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_ent <= i_q_entry;
        if (advance && r_act) begin
            r_out_kind <= sel;
            r_out_data <= beat;
            r_out_last <= (rest == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    a_act_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_mask != '0)) else $error("active run with empty mask");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind <= KIND_DEPLOY)) else $error("bad message kind");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && advance && (rest == '0) && !load) |=> !r_act)
        else $error("run not closed after last beat");

endmodule

// ===== hw/rtl/actuator_command_refresh_scheduler.sv =====
// top level: config registers, front end, run queue and message back end
//
// slave stream carries gamepad, station heartbeat, disable and service beats
// (kind in tuser). gamepad beats update the seven motor targets, heartbeat and
// disable beats set the enable flag; none of these produce output.
// a service beat carries the ms timestamp and schedules up to five messages
// (heartbeat, drive, intake, dump, deploy, in that order), each only if due;
// the master stream sends them with tlast on the final message of the run.
// the slave side takes one beat per cycle while the run queue has room.
// the first message of a service beat passes the queue entry, the back end run
// registers and the output register; then one message per cycle while the
// master side is ready, up to five per run; the back end expander is the
// rate limit for bursts of service beats.
// a stalled master side holds its beat in the output register; the front end
// keeps accepting until the queue fills, then drops tready. config writes take
// effect the next cycle; the user must make them while idle, unenforced.
// synchronous reset restores register defaults, clears targets, sent values,
// send timestamps and the enable flag, and empties the queue and output.
module actuator_command_refresh_scheduler #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [acrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // left_stick_y, right_stick_y, dpad_up, dpad_down, button_a, button_b,
    // left_bumper, right_bumper, left_trigger, right_trigger, time_or_enable
    input  logic [acrs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value_front_left, value_front_right, value_back_left, value_back_right,
    // robot_enabled
    output logic [acrs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // message_kind
    output logic [2:0]                        m_axis_tuser,
    // last_of_run
    output logic                              m_axis_tlast
);
    import acrs_pkg::*;

    t_cfg      r_cfg;
    logic      accept;
    logic      q_full;
    logic      push;
    t_entry    push_entry;
    logic      q_valid;
    logic      q_pop;
    t_entry    q_entry;
    t_kind     out_kind;
    t_out_data out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hb_period    <= RST_HB_PERIOD;
            r_cfg.ref_period   <= RST_REF_PERIOD;
            r_cfg.crawl        <= RST_CRAWL;
            r_cfg.intake       <= RST_INTAKE;
            r_cfg.dump         <= RST_DUMP;
            r_cfg.deploy_low   <= RST_DEPLOY_LOW;
            r_cfg.deploy_raise <= RST_DEPLOY_RAIS;
            r_cfg.deadzone     <= RST_DEADZONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HB_PERIOD:   r_cfg.hb_period    <= i_cfg_data;
                CFG_REF_PERIOD:  r_cfg.ref_period   <= i_cfg_data;
                CFG_CRAWL:       r_cfg.crawl        <= i_cfg_data[6:0];
                CFG_INTAKE:      r_cfg.intake       <= i_cfg_data[6:0];
                CFG_DUMP:        r_cfg.dump         <= i_cfg_data[6:0];
                CFG_DEPLOY_LOW:  r_cfg.deploy_low   <= i_cfg_data[7:0];
                CFG_DEPLOY_RAIS: r_cfg.deploy_raise <= i_cfg_data[7:0];
                CFG_DEADZONE:    r_cfg.deadzone     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    acrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_op     (t_op'(s_axis_tuser)),
        .i_data   (t_in_data'(s_axis_tdata)),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    acrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    acrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (out_kind),
        .o_data    (out_data),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = out_data;

endmodule
